// ----- src/crsg_pkg.sv -----
// ----------------------------------------------------------------------------
// crsg_pkg
// Shared constants and types of the circle ring span generator.
// ----------------------------------------------------------------------------
`default_nettype none

package crsg_pkg;

  // Field widths that the item format fixes.
  localparam int CTR_W   = 13;  // signed center coordinates
  localparam int RAD_W   = 12;  // radius and thickness
  localparam int CLIP_W  = 12;  // clip box registers and span columns
  localparam int COLOR_W = 16;  // RGB565 color
  localparam int SQ_W    = 2 * RAD_W;  // squares of radius-sized values

  // Defaults of the top-level parameters.
  localparam int ROOT_BITS_DEF  = 13;
  localparam int COORD_BITS_DEF = 11;

  // Reset value of the right and bottom clip edges.
  localparam logic [CLIP_W-1:0] CLIP_EDGE_RST = CLIP_W'(1 << 11);

  localparam int REG_IDX_W = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_CLIP_LEFT   = 2'd0,
    REG_CLIP_TOP    = 2'd1,
    REG_CLIP_RIGHT  = 2'd2,
    REG_CLIP_BOTTOM = 2'd3
  } crsg_reg_e;

  typedef struct packed {
    logic [CLIP_W-1:0] left;
    logic [CLIP_W-1:0] top;
    logic [CLIP_W-1:0] right;
    logic [CLIP_W-1:0] bottom;
  } crsg_clip_t;

  // Status of one finished row between the span stages and the emitter.
  typedef struct packed {
    logic vld;
    logic keep_a;
    logic keep_b;
  } crsg_keep_t;

endpackage

`default_nettype wire

// ----- src/circle_ring_span_generator.sv -----
// ----------------------------------------------------------------------------
// circle_ring_span_generator
// Clipped scanline spans of a filled ring or disc for one requested row.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Contents
// s_axis    in         one row request: center, radius, thickness, row, color
// m_axis    out        one clipped span; tlast marks the final span of a row
// cfg       in         clip box register write, no wait, no read-back
//
// One request is taken per cycle while tready is high. A row with a left and
// a right span holds the output register for two transfers, so a row right
// behind it waits in the last span stage and tready stays low while both
// spans are pending. A request passes the front stages, the square root
// pipeline, which resolves one result bit per stage, and the span stages.
// Reset clears the valid bits of all stages and loads the clip box to
// 0, 0, 2048, 2048. When the output stalls with a row in the last span stage
// that the output register cannot take, the whole pipeline holds and tready
// drops, even if earlier stages are empty; while the last span stage is
// empty, requests keep flowing in under a stalled output.
// ----------------------------------------------------------------------------
`default_nettype none

module circle_ring_span_generator #(
  parameter  int ROOT_BITS  = crsg_pkg::ROOT_BITS_DEF,
  parameter  int COORD_BITS = crsg_pkg::COORD_BITS_DEF,
  localparam int IN_RAW     = 2 * crsg_pkg::CTR_W + 2 * crsg_pkg::RAD_W + COORD_BITS
                              + crsg_pkg::COLOR_W,
  localparam int IN_W       = ((IN_RAW + 7) / 8) * 8,
  localparam int OUT_RAW    = COORD_BITS + 2 * crsg_pkg::CLIP_W + crsg_pkg::COLOR_W,
  localparam int OUT_W      = ((OUT_RAW + 7) / 8) * 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Row requests.
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // center_x, center_y, radius, thickness, row, color (lowest bits first)
  input  wire logic [IN_W-1:0]                   s_axis_tdata,
  // Spans.
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // span_row, span_start, span_end, span_color (lowest bits first)
  output logic [OUT_W-1:0]                       m_axis_tdata,
  output logic                                   m_axis_tlast,
  // Clip box registers.
  input  wire logic                              cfg_we_i,
  input  wire logic [crsg_pkg::REG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [crsg_pkg::CLIP_W-1:0]       cfg_data_i
);

  // Bit offsets of the request fields.
  localparam int OFF_CY    = crsg_pkg::CTR_W;
  localparam int OFF_R     = OFF_CY + crsg_pkg::CTR_W;
  localparam int OFF_TH    = OFF_R + crsg_pkg::RAD_W;
  localparam int OFF_ROW   = OFF_TH + crsg_pkg::RAD_W;
  localparam int OFF_COLOR = OFF_ROW + COORD_BITS;

  // Sideband that travels beside the square roots: inner flag, color, row,
  // center column.
  localparam int SIDE_W = 1 + crsg_pkg::COLOR_W + COORD_BITS + crsg_pkg::CTR_W;

  crsg_pkg::crsg_clip_t clip_q;

  // Pipeline enable: every stage moves together. It is high whenever the last
  // span stage is empty or the output register is about to take its row.
  logic en;
  logic take;

  // Front end to square roots.
  logic                               fr_vld;
  logic signed [crsg_pkg::CTR_W-1:0]  fr_cx;
  logic [COORD_BITS-1:0]              fr_y;
  logic [crsg_pkg::COLOR_W-1:0]       fr_color;
  logic [crsg_pkg::SQ_W-1:0]          fr_rad_out, fr_rad_in;
  logic                               fr_inner;

  // Square roots to span stages.
  logic                               rt_vld;
  logic [ROOT_BITS-1:0]               rt_wo, rt_wi;
  logic [SIDE_W-1:0]                  rt_side;

  // Span stages to output register.
  crsg_pkg::crsg_keep_t               sp_ctl;
  logic [COORD_BITS-1:0]              sp_y;
  logic [crsg_pkg::COLOR_W-1:0]       sp_color;
  logic [crsg_pkg::CLIP_W-1:0]        sp_sa, sp_ea, sp_sb, sp_eb;

  // Clip box registers. All indexes are defined, so every write lands.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q.left   <= '0;
      clip_q.top    <= '0;
      clip_q.right  <= crsg_pkg::CLIP_EDGE_RST;
      clip_q.bottom <= crsg_pkg::CLIP_EDGE_RST;
    end else if (cfg_we_i) begin
      unique case (crsg_pkg::crsg_reg_e'(cfg_idx_i))
        crsg_pkg::REG_CLIP_LEFT:   clip_q.left   <= cfg_data_i;
        crsg_pkg::REG_CLIP_TOP:    clip_q.top    <= cfg_data_i;
        crsg_pkg::REG_CLIP_RIGHT:  clip_q.right  <= cfg_data_i;
        crsg_pkg::REG_CLIP_BOTTOM: clip_q.bottom <= cfg_data_i;
      endcase
    end
  end

  assign en            = !sp_ctl.vld || take;
  assign s_axis_tready = en;

  // Rejection of empty rows, squaring and radicands.
  crsg_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .in_vld_i  (s_axis_tvalid),
    .cx_i      ($signed(s_axis_tdata[OFF_CY-1:0])),
    .cy_i      ($signed(s_axis_tdata[OFF_R-1:OFF_CY])),
    .r_i       (s_axis_tdata[OFF_TH-1:OFF_R]),
    .th_i      (s_axis_tdata[OFF_ROW-1:OFF_TH]),
    .y_i       (s_axis_tdata[OFF_COLOR-1:OFF_ROW]),
    .color_i   (s_axis_tdata[OFF_COLOR+crsg_pkg::COLOR_W-1:OFF_COLOR]),
    .clip_i    (clip_q),
    .vld_o     (fr_vld),
    .cx_o      (fr_cx),
    .y_o       (fr_y),
    .color_o   (fr_color),
    .rad_out_o (fr_rad_out),
    .rad_in_o  (fr_rad_in),
    .inner_o   (fr_inner)
  );

  // Outer and inner half-widths side by side.
  crsg_root #(
    .ROOT_BITS (ROOT_BITS),
    .SIDE_W    (SIDE_W)
  ) u_root (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (fr_vld),
    .rad_a_i  (fr_rad_out),
    .rad_b_i  (fr_rad_in),
    .side_i   ({fr_inner, fr_color, fr_y, fr_cx}),
    .vld_o    (rt_vld),
    .root_a_o (rt_wo),
    .root_b_o (rt_wi),
    .side_o   (rt_side)
  );

  crsg_span #(
    .ROOT_BITS  (ROOT_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_span (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .vld_i     (rt_vld),
    .wo_i      (rt_wo),
    .wi_i      (rt_wi),
    .cx_i      ($signed(rt_side[crsg_pkg::CTR_W-1:0])),
    .y_i       (rt_side[crsg_pkg::CTR_W+COORD_BITS-1:crsg_pkg::CTR_W]),
    .color_i   (rt_side[SIDE_W-2:crsg_pkg::CTR_W+COORD_BITS]),
    .inner_i   (rt_side[SIDE_W-1]),
    .clip_i    (clip_q),
    .ctl_o     (sp_ctl),
    .y_o       (sp_y),
    .color_o   (sp_color),
    .start_a_o (sp_sa),
    .end_a_o   (sp_ea),
    .start_b_o (sp_sb),
    .end_b_o   (sp_eb)
  );

  // Output register; a row with two spans sends the left one first.
  crsg_emit #(
    .COORD_BITS (COORD_BITS)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (sp_ctl),
    .y_i        (sp_y),
    .color_i    (sp_color),
    .start_a_i  (sp_sa),
    .end_a_i    (sp_ea),
    .start_b_i  (sp_sb),
    .end_b_i    (sp_eb),
    .take_o     (take),
    .out_vld_o  (m_axis_tvalid),
    .out_rdy_i  (m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ----- src/crsg_front.sv -----
// ----------------------------------------------------------------------------
// crsg_front
// Input register, row rejection, squaring and radicand stages.
// ----------------------------------------------------------------------------
`default_nettype none

module crsg_front #(
  parameter int COORD_BITS = crsg_pkg::COORD_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 en_i,
  input  wire logic                                 in_vld_i,
  input  wire logic signed [crsg_pkg::CTR_W-1:0]    cx_i,
  input  wire logic signed [crsg_pkg::CTR_W-1:0]    cy_i,
  input  wire logic [crsg_pkg::RAD_W-1:0]           r_i,
  input  wire logic [crsg_pkg::RAD_W-1:0]           th_i,
  input  wire logic [COORD_BITS-1:0]                y_i,
  input  wire logic [crsg_pkg::COLOR_W-1:0]         color_i,
  input  wire crsg_pkg::crsg_clip_t                 clip_i,
  output logic                                      vld_o,
  output logic signed [crsg_pkg::CTR_W-1:0]         cx_o,
  output logic [COORD_BITS-1:0]                     y_o,
  output logic [crsg_pkg::COLOR_W-1:0]              color_o,
  output logic [crsg_pkg::SQ_W-1:0]                 rad_out_o,
  output logic [crsg_pkg::SQ_W-1:0]                 rad_in_o,
  output logic                                      inner_o
);

  localparam int DW = ((COORD_BITS + 1 > crsg_pkg::CTR_W) ? COORD_BITS + 1
                                                          : crsg_pkg::CTR_W) + 1;
  localparam int YW = (COORD_BITS > crsg_pkg::CLIP_W) ? COORD_BITS : crsg_pkg::CLIP_W;

  // Stage A: registered input item.
  logic                                a_vld_q;
  logic signed [crsg_pkg::CTR_W-1:0]   a_cx_q, a_cy_q;
  logic [crsg_pkg::RAD_W-1:0]          a_r_q, a_th_q;
  logic [COORD_BITS-1:0]               a_y_q;
  logic [crsg_pkg::COLOR_W-1:0]        a_color_q;

  // Stage B: row checks done, distance magnitude and inner radius.
  logic                                b_vld_q, b_vld_d;
  logic signed [crsg_pkg::CTR_W-1:0]   b_cx_q;
  logic [crsg_pkg::RAD_W-1:0]          b_dm_q, b_r_q, b_ri_q, b_ri_d;
  logic [COORD_BITS-1:0]               b_y_q;
  logic [crsg_pkg::COLOR_W-1:0]        b_color_q;

  // Stage C: squares.
  logic                                c_vld_q;
  logic signed [crsg_pkg::CTR_W-1:0]   c_cx_q;
  logic [crsg_pkg::SQ_W-1:0]           c_r2_q, c_d2_q, c_i2_q;
  logic [COORD_BITS-1:0]               c_y_q;
  logic [crsg_pkg::COLOR_W-1:0]        c_color_q;

  // Stage D: radicands of the outer and inner half-widths.
  logic                                d_vld_q;
  logic signed [crsg_pkg::CTR_W-1:0]   d_cx_q;
  logic [crsg_pkg::SQ_W-1:0]           d_ro_q, d_ri_q, d_ri_d;
  logic                                d_inner_q, d_inner_d;
  logic [COORD_BITS-1:0]               d_y_q;
  logic [crsg_pkg::COLOR_W-1:0]        d_color_q;

  logic signed [DW-1:0]                dy;
  logic [DW-1:0]                       dmag;
  logic                                in_circle, in_rows;
  logic signed [crsg_pkg::SQ_W:0]      wi2;

  // The row must lie within the radius of the center and inside the clip rows.
  always_comb begin
    dy        = $signed(DW'(a_y_q)) - DW'(a_cy_q);
    dmag      = dy[DW-1] ? DW'(-dy) : DW'(dy);
    in_circle = dmag <= DW'(a_r_q);
    in_rows   = (YW'(a_y_q) >= YW'(clip_i.top)) && (YW'(a_y_q) < YW'(clip_i.bottom));
    b_vld_d   = a_vld_q && (a_r_q != '0) && (a_th_q != '0) && in_circle && in_rows;
    b_ri_d    = (a_r_q > a_th_q) ? a_r_q - a_th_q : '0;
  end

  // A positive inner radicand means the hole reaches this row.
  always_comb begin
    wi2       = $signed({1'b0, c_i2_q}) - $signed({1'b0, c_d2_q});
    d_inner_d = !wi2[crsg_pkg::SQ_W] && (wi2 != '0);
    d_ri_d    = d_inner_d ? wi2[crsg_pkg::SQ_W-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= in_vld_i;
      b_vld_q <= b_vld_d;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_cx_q    <= cx_i;
      a_cy_q    <= cy_i;
      a_r_q     <= r_i;
      a_th_q    <= th_i;
      a_y_q     <= y_i;
      a_color_q <= color_i;

      b_cx_q    <= a_cx_q;
      b_dm_q    <= dmag[crsg_pkg::RAD_W-1:0];
      b_r_q     <= a_r_q;
      b_ri_q    <= b_ri_d;
      b_y_q     <= a_y_q;
      b_color_q <= a_color_q;

      c_cx_q    <= b_cx_q;
      c_r2_q    <= crsg_pkg::SQ_W'(b_r_q) * crsg_pkg::SQ_W'(b_r_q);
      c_d2_q    <= crsg_pkg::SQ_W'(b_dm_q) * crsg_pkg::SQ_W'(b_dm_q);
      c_i2_q    <= crsg_pkg::SQ_W'(b_ri_q) * crsg_pkg::SQ_W'(b_ri_q);
      c_y_q     <= b_y_q;
      c_color_q <= b_color_q;

      d_cx_q    <= c_cx_q;
      d_ro_q    <= c_r2_q - c_d2_q;
      d_ri_q    <= d_ri_d;
      d_inner_q <= d_inner_d;
      d_y_q     <= c_y_q;
      d_color_q <= c_color_q;
    end
  end

  assign vld_o     = d_vld_q;
  assign cx_o      = d_cx_q;
  assign y_o       = d_y_q;
  assign color_o   = d_color_q;
  assign rad_out_o = d_ro_q;
  assign rad_in_o  = d_ri_q;
  assign inner_o   = d_inner_q;

endmodule

`default_nettype wire

// ----- src/crsg_root.sv -----
// ----------------------------------------------------------------------------
// crsg_root
// Two pipelined digit-by-digit integer square roots, one result bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none

module crsg_root #(
  parameter int ROOT_BITS = crsg_pkg::ROOT_BITS_DEF,
  parameter int SIDE_W    = 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          vld_i,
  input  wire logic [crsg_pkg::SQ_W-1:0]     rad_a_i,
  input  wire logic [crsg_pkg::SQ_W-1:0]     rad_b_i,
  input  wire logic [SIDE_W-1:0]             side_i,
  output logic                               vld_o,
  output logic [ROOT_BITS-1:0]               root_a_o,
  output logic [ROOT_BITS-1:0]               root_b_o,
  output logic [SIDE_W-1:0]                  side_o
);

  localparam int W = ((2 * ROOT_BITS > crsg_pkg::SQ_W) ? 2 * ROOT_BITS
                                                       : crsg_pkg::SQ_W) + 1;

  logic                        vld_q   [ROOT_BITS];
  logic [crsg_pkg::SQ_W-1:0]   rem_a_q [ROOT_BITS];
  logic [crsg_pkg::SQ_W-1:0]   rem_b_q [ROOT_BITS];
  logic [ROOT_BITS-1:0]        acc_a_q [ROOT_BITS];
  logic [ROOT_BITS-1:0]        acc_b_q [ROOT_BITS];
  logic [SIDE_W-1:0]           side_q  [ROOT_BITS];

  for (genvar i = 0; i < ROOT_BITS; i++) begin : g_step
    localparam int K = ROOT_BITS - 1 - i;

    logic                        vld_in;
    logic [crsg_pkg::SQ_W-1:0]   rem_a_in, rem_b_in;
    logic [ROOT_BITS-1:0]        acc_a_in, acc_b_in;
    logic [SIDE_W-1:0]           side_in;
    logic [W-1:0]                trial_a, trial_b;
    logic                        take_a, take_b;

    if (i == 0) begin : g_first
      assign vld_in   = vld_i;
      assign rem_a_in = rad_a_i;
      assign rem_b_in = rad_b_i;
      assign acc_a_in = '0;
      assign acc_b_in = '0;
      assign side_in  = side_i;
    end else begin : g_next
      assign vld_in   = vld_q[i-1];
      assign rem_a_in = rem_a_q[i-1];
      assign rem_b_in = rem_b_q[i-1];
      assign acc_a_in = acc_a_q[i-1];
      assign acc_b_in = acc_b_q[i-1];
      assign side_in  = side_q[i-1];
    end

    // (acc + 2^K)^2 - acc^2 = acc * 2^(K+1) + 2^(2K); the bit is kept when the
    // remainder covers that increase.
    always_comb begin
      trial_a = (W'(acc_a_in) << (K + 1)) | (W'(1) << (2 * K));
      trial_b = (W'(acc_b_in) << (K + 1)) | (W'(1) << (2 * K));
      take_a  = W'(rem_a_in) >= trial_a;
      take_b  = W'(rem_b_in) >= trial_b;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_a_q[i] <= take_a ? rem_a_in - trial_a[crsg_pkg::SQ_W-1:0] : rem_a_in;
        rem_b_q[i] <= take_b ? rem_b_in - trial_b[crsg_pkg::SQ_W-1:0] : rem_b_in;
        acc_a_q[i] <= take_a ? (acc_a_in | (ROOT_BITS'(1) << K)) : acc_a_in;
        acc_b_q[i] <= take_b ? (acc_b_in | (ROOT_BITS'(1) << K)) : acc_b_in;
        side_q[i]  <= side_in;
      end
    end
  end

  assign vld_o    = vld_q[ROOT_BITS-1];
  assign root_a_o = acc_a_q[ROOT_BITS-1];
  assign root_b_o = acc_b_q[ROOT_BITS-1];
  assign side_o   = side_q[ROOT_BITS-1];

endmodule

`default_nettype wire

// ----- src/crsg_span.sv -----
// ----------------------------------------------------------------------------
// crsg_span
// Span bounds from the half-widths, then clipping to the clip columns.
// ----------------------------------------------------------------------------
`default_nettype none

module crsg_span #(
  parameter int ROOT_BITS  = crsg_pkg::ROOT_BITS_DEF,
  parameter int COORD_BITS = crsg_pkg::COORD_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                en_i,
  input  wire logic                                vld_i,
  input  wire logic [ROOT_BITS-1:0]                wo_i,
  input  wire logic [ROOT_BITS-1:0]                wi_i,
  input  wire logic signed [crsg_pkg::CTR_W-1:0]   cx_i,
  input  wire logic [COORD_BITS-1:0]               y_i,
  input  wire logic [crsg_pkg::COLOR_W-1:0]        color_i,
  input  wire logic                                inner_i,
  input  wire crsg_pkg::crsg_clip_t                clip_i,
  output crsg_pkg::crsg_keep_t                     ctl_o,
  output logic [COORD_BITS-1:0]                    y_o,
  output logic [crsg_pkg::COLOR_W-1:0]             color_o,
  output logic [crsg_pkg::CLIP_W-1:0]              start_a_o,
  output logic [crsg_pkg::CLIP_W-1:0]              end_a_o,
  output logic [crsg_pkg::CLIP_W-1:0]              start_b_o,
  output logic [crsg_pkg::CLIP_W-1:0]              end_b_o
);

  localparam int XW = ((ROOT_BITS + 1 > crsg_pkg::CTR_W) ? ROOT_BITS + 1
                                                         : crsg_pkg::CTR_W) + 2;

  logic signed [XW-1:0]   cxw, wow, wiw;
  logic signed [XW-1:0]   x0a_d, x1a_d, x0b_d, x1b_d;

  logic                   e_vld_q, e_two_q;
  logic signed [XW-1:0]   e_x0a_q, e_x1a_q, e_x0b_q, e_x1b_q;
  logic [COORD_BITS-1:0]  e_y_q;
  logic [crsg_pkg::COLOR_W-1:0] e_color_q;

  logic signed [XW-1:0]   lo, hi, sa, ea, sb, eb;
  logic                   keep_a_d, keep_b_d;

  logic                   f_vld_q, f_keep_a_q, f_keep_b_q;
  logic [COORD_BITS-1:0]  f_y_q;
  logic [crsg_pkg::COLOR_W-1:0] f_color_q;
  logic [crsg_pkg::CLIP_W-1:0]  f_sa_q, f_ea_q, f_sb_q, f_eb_q;

  // Without a hole the first span covers the whole chord; with one, the left
  // span ends just past the inner edge and the right span starts on it.
  always_comb begin
    cxw   = XW'(cx_i);
    wow   = $signed(XW'(wo_i));
    wiw   = $signed(XW'(wi_i));
    x0a_d = cxw - wow;
    x1b_d = cxw + wow + XW'(1);
    x1a_d = inner_i ? cxw - wiw + XW'(1) : x1b_d;
    x0b_d = cxw + wiw;
  end

  // Clip in x; a span left empty is dropped.
  always_comb begin
    lo       = $signed(XW'(clip_i.left));
    hi       = $signed(XW'(clip_i.right));
    sa       = (e_x0a_q < lo) ? lo : e_x0a_q;
    ea       = (e_x1a_q > hi) ? hi : e_x1a_q;
    sb       = (e_x0b_q < lo) ? lo : e_x0b_q;
    eb       = (e_x1b_q > hi) ? hi : e_x1b_q;
    keep_a_d = ea > sa;
    keep_b_d = e_two_q && (eb > sb);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
      f_vld_q <= 1'b0;
    end else if (en_i) begin
      e_vld_q <= vld_i;
      f_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_two_q    <= inner_i;
      e_x0a_q    <= x0a_d;
      e_x1a_q    <= x1a_d;
      e_x0b_q    <= x0b_d;
      e_x1b_q    <= x1b_d;
      e_y_q      <= y_i;
      e_color_q  <= color_i;

      f_keep_a_q <= keep_a_d;
      f_keep_b_q <= keep_b_d;
      f_sa_q     <= sa[crsg_pkg::CLIP_W-1:0];
      f_ea_q     <= ea[crsg_pkg::CLIP_W-1:0];
      f_sb_q     <= sb[crsg_pkg::CLIP_W-1:0];
      f_eb_q     <= eb[crsg_pkg::CLIP_W-1:0];
      f_y_q      <= e_y_q;
      f_color_q  <= e_color_q;
    end
  end

  assign ctl_o.vld    = f_vld_q;
  assign ctl_o.keep_a = f_keep_a_q;
  assign ctl_o.keep_b = f_keep_b_q;
  assign y_o          = f_y_q;
  assign color_o      = f_color_q;
  assign start_a_o    = f_sa_q;
  assign end_a_o      = f_ea_q;
  assign start_b_o    = f_sb_q;
  assign end_b_o      = f_eb_q;

endmodule

`default_nettype wire

// ----- src/crsg_emit.sv -----
// ----------------------------------------------------------------------------
// crsg_emit
// Output register that sends the one or two spans of a row in order.
// ----------------------------------------------------------------------------
`default_nettype none

module crsg_emit #(
  parameter  int COORD_BITS = crsg_pkg::COORD_BITS_DEF,
  localparam int OUT_RAW    = COORD_BITS + 2 * crsg_pkg::CLIP_W + crsg_pkg::COLOR_W,
  localparam int OUT_W      = ((OUT_RAW + 7) / 8) * 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire crsg_pkg::crsg_keep_t          ctl_i,
  input  wire logic [COORD_BITS-1:0]         y_i,
  input  wire logic [crsg_pkg::COLOR_W-1:0]  color_i,
  input  wire logic [crsg_pkg::CLIP_W-1:0]   start_a_i,
  input  wire logic [crsg_pkg::CLIP_W-1:0]   end_a_i,
  input  wire logic [crsg_pkg::CLIP_W-1:0]   start_b_i,
  input  wire logic [crsg_pkg::CLIP_W-1:0]   end_b_i,
  output logic                               take_o,
  output logic                               out_vld_o,
  input  wire logic                          out_rdy_i,
  output logic [OUT_W-1:0]                   out_data_o,
  output logic                               out_last_o
);

  logic                          pa_q, pb_q;
  logic [COORD_BITS-1:0]         y_q;
  logic [crsg_pkg::COLOR_W-1:0]  color_q;
  logic [crsg_pkg::CLIP_W-1:0]   sa_q, ea_q, sb_q, eb_q;
  logic [crsg_pkg::CLIP_W-1:0]   cur_start, cur_end;
  logic                          xfer, load;

  assign xfer   = out_vld_o && out_rdy_i;
  // A new row may enter when nothing stays pending after this cycle.
  assign take_o = (!pa_q && !pb_q) || (xfer && (pa_q ^ pb_q));
  assign load   = ctl_i.vld && take_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa_q <= 1'b0;
      pb_q <= 1'b0;
    end else if (load) begin
      pa_q <= ctl_i.keep_a;
      pb_q <= ctl_i.keep_b;
    end else if (xfer) begin
      if (pa_q) begin
        pa_q <= 1'b0;
      end else begin
        pb_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      y_q     <= y_i;
      color_q <= color_i;
      sa_q    <= start_a_i;
      ea_q    <= end_a_i;
      sb_q    <= start_b_i;
      eb_q    <= end_b_i;
    end
  end

  assign cur_start  = pa_q ? sa_q : sb_q;
  assign cur_end    = pa_q ? ea_q : eb_q;
  assign out_vld_o  = pa_q || pb_q;
  assign out_last_o = !(pa_q && pb_q);
  assign out_data_o = OUT_W'({color_q, cur_end, cur_start, y_q});

`ifndef SYNTH
  a_no_take_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pa_q && pb_q) |-> !take_o)
    else $error("emitter took a row while two spans were pending");

  a_load_sets_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (pa_q == $past(ctl_i.keep_a)) && (pb_q == $past(ctl_i.keep_b)))
    else $error("pending spans do not match the loaded row");

  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && out_last_o && !load) |=> !out_vld_o)
    else $error("span still pending after the last transfer of a row");

  a_span_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_o |-> (cur_start < cur_end))
    else $error("empty span presented on the output");
`endif

endmodule

`default_nettype wire
